### src/lidar_point_camera_projection_core_defines.svh
// ----------------------------------------------------------------------------
// lidar point camera projection: assertion macros
// Concurrent assertion helpers used by the projection core output stage.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_CAMERA_PROJECTION_CORE_DEFINES_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold in every cycle out of reset
`define LPCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LPCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LPCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/lpcp_pkg.sv
// ----------------------------------------------------------------------------
// lpcp_pkg
// Shared widths, register indexes, projection matrix and stage types.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcp_pkg;

  // field and datapath widths
  localparam int COORD_W   = 32;
  localparam int COEF_W    = 27;
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int H_W       = 64;
  localparam int PIX_W     = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] IMAGE_COLS_RST = 13'd1242;
  localparam logic [CFG_W-1:0] IMAGE_ROWS_RST = 13'd375;

  typedef logic signed [COEF_W-1:0] coef_t;

  // composed projection matrix, Q10.16, row-major 3x4
  localparam coef_t PROJ [3][4] = '{
    '{ 27'sd39358304, -27'sd46409571,   -27'sd628816, -27'sd10323450},
    '{ 27'sd11699700,    27'sd351456, -27'sd46415411,  -27'sd7400505},
    '{    27'sd65535,      -27'sd118,      -27'sd426,    -27'sd21482}
  };

  // sign and depth flags carried along the divider
  typedef struct packed {
    logic pos;
    logic neg_col;
    logic neg_row;
  } div_flags_t;

  // one result item
  typedef struct packed {
    logic             on_image;
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
  } pixel_t;

endpackage

`default_nettype wire

### src/lpcp_proj.sv
// ----------------------------------------------------------------------------
// lpcp_proj
// Three-stage matrix product: point times 3x4 matrix into homogeneous u, v, w.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcp_proj #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [lpcp_pkg::COORD_W-1:0] point_x,
  input  logic signed [lpcp_pkg::COORD_W-1:0] point_y,
  input  logic signed [lpcp_pkg::COORD_W-1:0] point_z,
  output logic                                out_valid,
  output logic signed [lpcp_pkg::H_W-1:0]     h_u,
  output logic signed [lpcp_pkg::H_W-1:0]     h_v,
  output logic signed [lpcp_pkg::H_W-1:0]     h_w
);

  localparam int PROD_W = lpcp_pkg::PROD_W;
  localparam int H_W    = lpcp_pkg::H_W;

  logic signed [lpcp_pkg::COORD_W-1:0] pt [3];
  logic signed [H_W-1:0]               trans [3];
  logic signed [PROD_W-1:0]            prod_r [3][3];
  logic signed [H_W-1:0]               sum_a_r [3];
  logic signed [H_W-1:0]               sum_b_r [3];
  logic signed [H_W-1:0]               h_r [3];
  logic [2:0]                          vld_r;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  // translation column scaled to the product format
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trans[i] = H_W'(lpcp_pkg::PROJ[i][3]) <<< COORD_FRAC_BITS;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  // stage 1: nine products, stage 2: pair sums, stage 3: row sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= PROD_W'(pt[j]) * PROD_W'(lpcp_pkg::PROJ[i][j]);
        end
        sum_a_r[i] <= H_W'(prod_r[i][0]) + H_W'(prod_r[i][1]);
        sum_b_r[i] <= H_W'(prod_r[i][2]) + trans[i];
        h_r[i]     <= sum_a_r[i] + sum_b_r[i];
      end
    end
  end

  assign out_valid = vld_r[2];
  assign h_u       = h_r[0];
  assign h_v       = h_r[1];
  assign h_w       = h_r[2];

endmodule

`default_nettype wire

### src/lpcp_div_step.sv
// ----------------------------------------------------------------------------
// lpcp_div_step
// One registered restoring step for column and row quotients in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcp_div_step #(
  parameter int QW    = 13,
  parameter int SHIFT = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  lpcp_pkg::div_flags_t         in_flags,
  input  logic [lpcp_pkg::H_W-1:0]     in_rem_c,
  input  logic [lpcp_pkg::H_W-1:0]     in_rem_r,
  input  logic [lpcp_pkg::H_W-1:0]     in_dvsr,
  input  logic [QW-1:0]                in_q_c,
  input  logic [QW-1:0]                in_q_r,
  output logic                         out_valid,
  output lpcp_pkg::div_flags_t         out_flags,
  output logic [lpcp_pkg::H_W-1:0]     out_rem_c,
  output logic [lpcp_pkg::H_W-1:0]     out_rem_r,
  output logic [lpcp_pkg::H_W-1:0]     out_dvsr,
  output logic [QW-1:0]                out_q_c,
  output logic [QW-1:0]                out_q_r
);

  logic                         fit_c, fit_r;
  logic [lpcp_pkg::H_W-1:0]     rem_c_nxt, rem_r_nxt;
  logic [QW-1:0]                q_c_nxt, q_r_nxt;
  logic                         vld_r;
  lpcp_pkg::div_flags_t         flags_r;
  logic [lpcp_pkg::H_W-1:0]     rem_c_r, rem_r_r, dvsr_r;
  logic [QW-1:0]                q_c_r, q_r_r;

  // rem >= dvsr * 2^SHIFT exactly when rem >> SHIFT >= dvsr
  always_comb begin
    fit_c     = (in_rem_c >> SHIFT) >= in_dvsr;
    fit_r     = (in_rem_r >> SHIFT) >= in_dvsr;
    rem_c_nxt = fit_c ? (in_rem_c - (in_dvsr << SHIFT)) : in_rem_c;
    rem_r_nxt = fit_r ? (in_rem_r - (in_dvsr << SHIFT)) : in_rem_r;
    q_c_nxt        = in_q_c;
    q_c_nxt[SHIFT] = fit_c;
    q_r_nxt        = in_q_r;
    q_r_nxt[SHIFT] = fit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r <= in_flags;
      rem_c_r <= rem_c_nxt;
      rem_r_r <= rem_r_nxt;
      dvsr_r  <= in_dvsr;
      q_c_r   <= q_c_nxt;
      q_r_r   <= q_r_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_flags = flags_r;
  assign out_rem_c = rem_c_r;
  assign out_rem_r = rem_r_r;
  assign out_dvsr  = dvsr_r;
  assign out_q_c   = q_c_r;
  assign out_q_r   = q_r_r;

endmodule

`default_nettype wire

### src/lpcp_div.sv
// ----------------------------------------------------------------------------
// lpcp_div
// Sign split of u and v, then a chain of restoring steps dividing by w.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcp_div #(
  parameter int QW = 13
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [lpcp_pkg::H_W-1:0] h_u,
  input  logic signed [lpcp_pkg::H_W-1:0] h_v,
  input  logic signed [lpcp_pkg::H_W-1:0] h_w,
  output logic                            out_valid,
  output lpcp_pkg::div_flags_t            out_flags,
  output logic [QW-1:0]                   out_q_c,
  output logic [QW-1:0]                   out_q_r
);

  localparam int H_W = lpcp_pkg::H_W;

  lpcp_pkg::div_flags_t flags_nxt;
  logic [H_W-1:0]       abs_c_nxt, abs_r_nxt;

  logic [QW:0]          vld;
  lpcp_pkg::div_flags_t flg   [QW+1];
  logic [H_W-1:0]       rem_c [QW+1];
  logic [H_W-1:0]       rem_r [QW+1];
  logic [H_W-1:0]       dvsr  [QW+1];
  logic [QW-1:0]        q_c   [QW+1];
  logic [QW-1:0]        q_r   [QW+1];

  logic                 vld_r;
  lpcp_pkg::div_flags_t flags_r;
  logic [H_W-1:0]       abs_c_r, abs_r_r, dvsr_r;

  // magnitudes and signs; depth positive gates the whole result
  always_comb begin
    flags_nxt.pos     = !h_w[H_W-1] && (h_w != '0);
    flags_nxt.neg_col = h_u[H_W-1];
    flags_nxt.neg_row = h_v[H_W-1];
    abs_c_nxt = h_u[H_W-1] ? H_W'(-h_u) : H_W'(h_u);
    abs_r_nxt = h_v[H_W-1] ? H_W'(-h_v) : H_W'(h_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r <= flags_nxt;
      abs_c_r <= abs_c_nxt;
      abs_r_r <= abs_r_nxt;
      dvsr_r  <= H_W'(h_w);
    end
  end

  assign vld[0]   = vld_r;
  assign flg[0]   = flags_r;
  assign rem_c[0] = abs_c_r;
  assign rem_r[0] = abs_r_r;
  assign dvsr[0]  = dvsr_r;
  assign q_c[0]   = '0;
  assign q_r[0]   = '0;

  // one quotient bit per stage, most significant first; the top bit marks overflow
  for (genvar k = 0; k < QW; k++) begin : g_step
    lpcp_div_step #(
      .QW    (QW),
      .SHIFT (QW - 1 - k)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (vld[k]),
      .in_flags  (flg[k]),
      .in_rem_c  (rem_c[k]),
      .in_rem_r  (rem_r[k]),
      .in_dvsr   (dvsr[k]),
      .in_q_c    (q_c[k]),
      .in_q_r    (q_r[k]),
      .out_valid (vld[k+1]),
      .out_flags (flg[k+1]),
      .out_rem_c (rem_c[k+1]),
      .out_rem_r (rem_r[k+1]),
      .out_dvsr  (dvsr[k+1]),
      .out_q_c   (q_c[k+1]),
      .out_q_r   (q_r[k+1])
    );
  end

  assign out_valid = vld[QW];
  assign out_flags = flg[QW];
  assign out_q_c   = q_c[QW];
  assign out_q_r   = q_r[QW];

endmodule

`default_nettype wire

### src/lpcp_out.sv
// ----------------------------------------------------------------------------
// lpcp_out
// Bounds test, output register and skid stage toward the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lidar_point_camera_projection_core_defines.svh"

module lpcp_out #(
  parameter int QW            = 13,
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  lpcp_pkg::div_flags_t           in_flags,
  input  logic [QW-1:0]                  in_q_c,
  input  logic [QW-1:0]                  in_q_r,
  input  logic [lpcp_pkg::CFG_W-1:0]     image_cols,
  input  logic [lpcp_pkg::CFG_W-1:0]     image_rows,
  output logic                           en,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lpcp_pkg::pixel_t               out_pixel
);

  localparam int CW = (QW > lpcp_pkg::CFG_W) ? QW : lpcp_pkg::CFG_W;
  localparam logic [CW-1:0] MAX_B = CW'(MAX_IMAGE_DIM);

  logic [CW-1:0]    cols_ext, rows_ext, eff_c, eff_r;
  logic             on_image;
  lpcp_pkg::pixel_t res_nxt;

  logic             out_vld_r, sk_vld_r;
  lpcp_pkg::pixel_t out_res_r, sk_res_r;

  // bounds saturate at the largest image size
  always_comb begin
    cols_ext = CW'(image_cols);
    rows_ext = CW'(image_rows);
    eff_c    = (cols_ext > MAX_B) ? MAX_B : cols_ext;
    eff_r    = (rows_ext > MAX_B) ? MAX_B : rows_ext;
    // a negative numerator smaller than w still truncates to zero
    on_image = in_flags.pos
               && !(in_flags.neg_col && (in_q_c != '0))
               && !(in_flags.neg_row && (in_q_r != '0))
               && (CW'(in_q_c) < eff_c)
               && (CW'(in_q_r) < eff_r);
    res_nxt.on_image = on_image;
    res_nxt.col      = on_image ? lpcp_pkg::PIX_W'(in_q_c) : '0;
    res_nxt.row      = on_image ? lpcp_pkg::PIX_W'(in_q_r) : '0;
  end

  // pipeline moves whenever the skid stage is empty
  assign en = !sk_vld_r;

  // output and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (sk_vld_r) begin
      if (out_ready) begin
        out_vld_r <= 1'b1;
        sk_vld_r  <= 1'b0;
      end
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= in_valid;
    end else if (in_valid) begin
      sk_vld_r <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (sk_vld_r) begin
      if (out_ready) begin
        out_res_r <= sk_res_r;
      end
    end else if (!out_vld_r || out_ready) begin
      out_res_r <= res_nxt;
    end else begin
      sk_res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_pixel = out_res_r;

  // checks
  `LPCP_ASSERT(a_skid_behind_out, clk, rst_n, !sk_vld_r || out_vld_r, "skid full with output empty")
  `LPCP_ASSERT(a_outside_zero, clk, rst_n, !(out_vld_r && !out_res_r.on_image) || ((out_res_r.col == '0) && (out_res_r.row == '0)), "pixel not zero outside image")
  `LPCP_ASSERT(a_skid_fill_on_stall, clk, rst_n, !$rose(sk_vld_r) || $past(out_vld_r && !out_ready), "skid filled without a stall")
  `LPCP_ASSERT_NEXT(a_skid_held, clk, rst_n, sk_vld_r && !out_ready, sk_vld_r, "skid lost while stalled")

endmodule

`default_nettype wire

### src/lidar_point_camera_projection_core.sv
// ----------------------------------------------------------------------------
// lidar_point_camera_projection_core
// Projects lidar points onto a camera image through a fixed 3x4 matrix.
//
// in_ channel: one point per transfer, x, y, z signed fixed point metres.
// out_ channel: one result per point, column, row and an inside flag;
//   column and row read zero when the point is behind the camera or off
//   the image. Results leave in input order.
// cfg_ port: image width (index 0) and height (index 1), written while idle.
// Pipeline: 3 product/sum stages, 1 sign stage, clog2(MAX_IMAGE_DIM)+1
//   divider steps and 1 output register.
// Throughput: one point per cycle while the skid stage is empty; the divider
//   is a chain of restoring steps, one quotient bit per stage.
// Reset clears all valid bits and loads width 1242 and height 375.
// When the receiver stalls, one result waits in the output register and a
//   second in a skid stage; in_tready then drops and the pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_camera_projection_core #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int MAX_IMAGE_DIM   = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [3*lpcp_pkg::COORD_W-1:0]    in_tdata,
  // pixel_col [11:0], pixel_row [23:12]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [2*lpcp_pkg::PIX_W-1:0]      out_tdata,
  // inside_image [0]
  output logic                              out_tuser,
  input  logic                              cfg_wen,
  input  logic [lpcp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpcp_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int QW = $clog2(MAX_IMAGE_DIM) + 1;
  localparam int CRD = lpcp_pkg::COORD_W;

  logic [lpcp_pkg::CFG_W-1:0]  image_cols_r, image_rows_r;
  logic                        en;
  logic                        proj_vld;
  logic signed [lpcp_pkg::H_W-1:0] h_u, h_v, h_w;
  logic                        div_vld;
  lpcp_pkg::div_flags_t        div_flags;
  logic [QW-1:0]               q_c, q_r;
  lpcp_pkg::pixel_t            pixel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_cols_r <= lpcp_pkg::IMAGE_COLS_RST;
      image_rows_r <= lpcp_pkg::IMAGE_ROWS_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lpcp_pkg::REG_IMAGE_COLS: image_cols_r <= cfg_wdata;
        lpcp_pkg::REG_IMAGE_ROWS: image_rows_r <= cfg_wdata;
      endcase
    end
  end

  assign in_tready = en;

  // matrix product
  lpcp_proj #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .point_x   (in_tdata[CRD-1:0]),
    .point_y   (in_tdata[2*CRD-1:CRD]),
    .point_z   (in_tdata[3*CRD-1:2*CRD]),
    .out_valid (proj_vld),
    .h_u       (h_u),
    .h_v       (h_v),
    .h_w       (h_w)
  );

  // division by depth
  lpcp_div #(
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (proj_vld),
    .h_u       (h_u),
    .h_v       (h_v),
    .h_w       (h_w),
    .out_valid (div_vld),
    .out_flags (div_flags),
    .out_q_c   (q_c),
    .out_q_r   (q_r)
  );

  // bounds test and result buffering
  lpcp_out #(
    .QW            (QW),
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (div_vld),
    .in_flags   (div_flags),
    .in_q_c     (q_c),
    .in_q_r     (q_r),
    .image_cols (image_cols_r),
    .image_rows (image_rows_r),
    .en         (en),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pixel  (pixel)
  );

  assign out_tdata = {pixel.row, pixel.col};
  assign out_tuser = pixel.on_image;

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: lidar point camera projection testbench
// Streams lidar points through the projection core and compares every pixel
// result with an in-house projection of the same point. Covers the image
// size registers at reset, zero, one, full size, saturated and random sizes,
// and at exact pixel edges. Random idling sits on both sides, with one long
// receiver hold that fills the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int     MAX_DIM    = 4096;
  localparam longint ONE_METRE  = 64'sd65536;
  localparam int     M          = 65536;
  localparam int     INT_MAX    = 32'h7fffffff;
  localparam int     INT_MIN    = 32'h80000000;
  localparam int     HOLD_LEN   = 300;
  localparam int     DRAIN_MAX  = 20000;
  localparam int     PIX_W      = lpcp_pkg::PIX_W;
  localparam int     CFG_W      = lpcp_pkg::CFG_W;
  localparam int     CFG_IDX_W  = lpcp_pkg::CFG_IDX_W;
  localparam int     COORD_W    = lpcp_pkg::COORD_W;

  // expected pixels and the projection that produces them
  class pixel_scoreboard;
    lpcp_pkg::pixel_t pixel_q[$];
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    int               mismatches;
    int               checked;
    int               inside_seen;

    function new();
      cols_reg    = lpcp_pkg::IMAGE_COLS_RST;
      rows_reg    = lpcp_pkg::IMAGE_ROWS_RST;
      mismatches  = 0;
      checked     = 0;
      inside_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        lpcp_pkg::REG_IMAGE_COLS: cols_reg = val;
        lpcp_pkg::REG_IMAGE_ROWS: rows_reg = val;
        default: ;
      endcase
    endfunction

    function longint bound(logic [CFG_W-1:0] reg_v);
      return (reg_v > MAX_DIM) ? MAX_DIM : longint'(reg_v);
    endfunction

    // homogeneous coordinates, then column and row when in front
    function bit locate(int x, int y, int z, output longint c, output longint r);
      longint px, py, pz, u, v, w;
      px = x;
      py = y;
      pz = z;
      u = 64'sd39358304 * px - 64'sd46409571 * py - 64'sd628816 * pz
        - 64'sd10323450 * ONE_METRE;
      v = 64'sd11699700 * px + 64'sd351456 * py - 64'sd46415411 * pz
        - 64'sd7400505 * ONE_METRE;
      w = 64'sd65535 * px - 64'sd118 * py - 64'sd426 * pz
        - 64'sd21482 * ONE_METRE;
      c = 0;
      r = 0;
      if (w <= 0) return 1'b0;
      c = u / w;
      r = v / w;
      return 1'b1;
    endfunction

    function lpcp_pkg::pixel_t project(int x, int y, int z);
      lpcp_pkg::pixel_t p;
      longint c, r;
      p = '0;
      if (locate(x, y, z, c, r) && c >= 0 && r >= 0 &&
          c < bound(cols_reg) && r < bound(rows_reg)) begin
        p.on_image = 1'b1;
        p.col      = c[PIX_W-1:0];
        p.row      = r[PIX_W-1:0];
      end
      return p;
    endfunction

    function void note_point(int x, int y, int z);
      pixel_q = {pixel_q, project(x, y, z)};
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 50) $display("mismatch: %s", what);
    endtask

    task check_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row, logic on_image);
      lpcp_pkg::pixel_t exp_px;
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("result col %0d row %0d inside %0b with none pending",
                                  col, row, on_image));
        return;
      end
      exp_px = pixel_q.pop_front();
      checked++;
      if (on_image) inside_seen++;
      if (on_image !== exp_px.on_image)
        report_mismatch($sformatf("result %0d inside %0b, predicted %0b",
                                  checked, on_image, exp_px.on_image));
      if (col !== exp_px.col)
        report_mismatch($sformatf("result %0d col %0d, predicted %0d",
                                  checked, col, exp_px.col));
      if (row !== exp_px.row)
        report_mismatch($sformatf("result %0d row %0d, predicted %0d",
                                  checked, row, exp_px.row));
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [3*COORD_W-1:0]   in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [2*PIX_W-1:0]     out_tdata;
  logic                   out_tuser;
  logic                   cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = lpcp_pkg::REG_IMAGE_COLS;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  pixel_scoreboard board = new();

  bit idling_on = 1'b1;
  bit hold_req  = 1'b0;
  int points_sent;
  int held_cycles;
  int long_holds;
  int size_settings;

  lidar_point_camera_projection_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result transfers and input back-pressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_pixel(out_tdata[PIX_W-1:0], out_tdata[2*PIX_W-1:PIX_W], out_tuser);
    if (rst_n && in_tvalid && !in_tready)
      held_cycles++;
  end

  // receiver: ready runs, idle bursts and the long hold
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        long_holds++;
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // one point transfer, then maybe an idle burst
  task send_point(int x, int y, int z);
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    board.note_point(x, y, z);
    points_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task wait_drained();
    int guard;
    guard = 0;
    while (board.pixel_q.size() != 0) begin
      @(posedge clk);
      guard++;
      if (guard > DRAIN_MAX) begin
        $display("timeout: %0d results still outstanding", board.pixel_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  endtask

  task close_phase();
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  // both size registers, written while the core is empty
  task set_image(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
    cfg_wen   <= 1'b1;
    cfg_index <= lpcp_pkg::REG_IMAGE_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= lpcp_pkg::REG_IMAGE_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    board.write_reg(lpcp_pkg::REG_IMAGE_COLS, cols);
    board.write_reg(lpcp_pkg::REG_IMAGE_ROWS, rows);
    size_settings++;
  endtask

  // point in the camera's field of view: 1 to 80 m ahead
  function automatic void scene_point(output int x, output int y, output int z);
    x = int'($urandom_range(32'h0001_0000, 32'h0050_0000));
    y = int'($urandom_range(0, 2 * x)) - x;
    z = int'($urandom_range(0, x)) - x / 2;
  endfunction

  function automatic void random_point(output int x, output int y, output int z);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      scene_point(x, y, z);
    end else if (pick < 85) begin
      x = int'($urandom);
      y = int'($urandom);
      z = int'($urandom);
    end else begin
      // close to the depth zero plane
      x = int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      y = int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      z = int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    end
  endfunction

  task send_random(int count);
    int x, y, z;
    repeat (count) begin
      random_point(x, y, z);
      send_point(x, y, z);
    end
  endtask

  task send_directed();
    send_point(0, 0, 0);
    send_point(M, 0, 0);
    send_point(1, 0, 0);
    send_point(M / 2, 0, 0);
    send_point(INT_MAX, INT_MAX, INT_MAX);
    send_point(INT_MIN, INT_MIN, INT_MIN);
    send_point(INT_MAX, 0, 0);
    send_point(INT_MIN, 0, 0);
    send_point(0, INT_MAX, 0);
    send_point(0, INT_MIN, 0);
    send_point(0, 0, INT_MAX);
    send_point(0, 0, INT_MIN);
    send_point(INT_MAX, INT_MIN, INT_MAX);
    send_point(INT_MIN, INT_MAX, INT_MIN);
    // depth exactly zero, then just in front
    send_point(21482, -377, 54);
    send_point(21483, -377, 54);
    // behind the camera
    send_point(-10 * M, 0, 0);
    // negative column, negative row
    send_point(10 * M, 10 * M, 0);
    send_point(10 * M, 0, 5 * M);
    // past the right and bottom edges
    send_point(10 * M, -10 * M, 0);
    send_point(10 * M, 0, -5 * M);
    send_point(20 * M, M, -M);
  endtask

  task probe_at(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows, int x, int y, int z);
    set_image(cols, rows);
    send_point(x, y, z);
    close_phase();
  endtask

  // size registers placed exactly on and one past a pixel
  task probe_image_edges(int rounds);
    int     x, y, z;
    longint c, r;
    bit     front;
    for (int k = 0; k < rounds; k++) begin
      do begin
        scene_point(x, y, z);
        front = board.locate(x, y, z, c, r);
      end while (!(front && c >= 0 && r >= 0 && c < MAX_DIM && r < MAX_DIM));
      probe_at(CFG_W'(c), CFG_W'(r + 1), x, y, z);
      probe_at(CFG_W'(c + 1), CFG_W'(r), x, y, z);
      probe_at(CFG_W'(c + 1), CFG_W'(r + 1), x, y, z);
    end
  endtask

  // run limit
  initial begin
    #4_000_000;
    $display("timeout: run did not complete");
    $display("CHECKS FAILED");
    $finish;
  end

  // main sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes
    send_directed();
    send_random(200);
    close_phase();

    set_image(13'd4096, 13'd4096);
    send_random(250);
    close_phase();

    // saturated sizes, with the receiver holding off
    set_image(13'd8191, 13'd5000);
    hold_req = 1'b1;
    send_random(200);
    close_phase();

    set_image(13'd0, 13'd375);
    send_random(150);
    close_phase();

    set_image(13'd1242, 13'd0);
    send_random(150);
    close_phase();

    set_image(13'd1, 13'd1);
    send_random(150);
    close_phase();

    set_image(CFG_W'($urandom_range(1, MAX_DIM)), CFG_W'($urandom_range(1, MAX_DIM)));
    send_random(250);
    close_phase();

    probe_image_edges(10);

    // back to reset sizes, no idling
    idling_on = 1'b0;
    set_image(lpcp_pkg::IMAGE_COLS_RST, lpcp_pkg::IMAGE_ROWS_RST);
    send_random(300);
    close_phase();
    repeat (30) @(posedge clk);

    $display("summary: %0d points sent over %0d image sizes, %0d results checked, %0d inside",
             points_sent, size_settings + 1, board.checked, board.inside_seen);
    $display("summary: %0d long receiver holds, %0d cycles with input held back",
             long_holds, held_cycles);
    if (board.mismatches == 0 && board.pixel_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/lpcp_pkg.sv
src/lpcp_proj.sv
src/lpcp_div_step.sv
src/lpcp_div.sv
src/lpcp_out.sv
src/lidar_point_camera_projection_core.sv
tb/tb.sv
